### hw/rtl/dti_pkg.sv
`timescale 1ns / 1ps

package dti_pkg;

   // sizes of the tree engine
   localparam int NODE_COUNT    = 256;
   localparam int FEATURE_COUNT = 16;
   localparam int MAX_DEPTH     = 16;
   localparam int CLASS_COUNT   = 16;

   localparam int NODE_W  = $clog2(NODE_COUNT);
   localparam int FEAT_W  = $clog2(FEATURE_COUNT);
   localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

   // action codes
   localparam logic [1:0] ACT_WRITE_NODE    = 2'd0;
   localparam logic [1:0] ACT_WRITE_FEATURE = 2'd1;
   localparam logic [1:0] ACT_CLASSIFY      = 2'd2;

   typedef struct packed {
      logic [1:0]         action;
      logic [7:0]         node_slot;
      logic [3:0]         split_feature;
      logic signed [31:0] split_threshold;
      logic [7:0]         left_child;
      logic [7:0]         right_child;
      logic               is_leaf;
      logic [3:0]         leaf_class;
      logic [3:0]         feature_slot;
      logic signed [31:0] feature_value;
   } req_type;

   typedef struct packed {
      logic [3:0] predicted_class;
      logic       depth_exceeded;
   } rsp_type;

   // one entry of the node table
   typedef struct packed {
      logic [3:0]         split_feature;
      logic signed [31:0] split_threshold;
      logic [7:0]         left_child;
      logic [7:0]         right_child;
      logic               is_leaf;
      logic [3:0]         leaf_class;
   } node_type;

endpackage

### hw/rtl/decision_tree_inference_core.sv
`timescale 1ns / 1ps

// Decision tree classifier. A write-node beat stores one node in a 256-entry
// node table held in RAM, a write-feature beat stores one signed Q16.16
// feature of the current sample, and neither gives a response. A classify beat
// walks the tree from node 0 and gives one response beat: the class of the leaf
// reached, or depth_exceeded with class 0 when no leaf turns up within MAX_DEPTH
// descents. The walk runs at one node per cycle, paced by the single read port
// of the node table, and at a leaf or at the depth limit it waits until the
// response slot is free before the response is registered. The core takes no
// request during a walk; it does take writes while a finished response still
// waits on rsp_ready. Node table and sample entries are undefined until
// written.
module decision_tree_inference_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dti_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dti_pkg::rsp_type rsp_data
);

   import dti_pkg::*;

   // sequencer states
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WALK = 1'b1;

   logic               state_ff, state_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic signed [31:0] sample_ff [FEATURE_COUNT];

   logic               req_fire;
   logic               out_free;
   logic               rsp_load;

   // node table port signals
   logic               tbl_wr_en;
   logic [NODE_W-1:0]  tbl_wr_addr;
   node_type           tbl_wr_data;
   logic               tbl_rd_en;
   logic [NODE_W-1:0]  tbl_rd_addr;
   logic [$bits(node_type)-1:0] tbl_rd_raw;
   node_type           node_rd;

   logic signed [31:0] feat_val;
   logic               go_left;
   logic               at_limit;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // node writes: out of range slots are dropped, class saturates
   always_comb begin
      tbl_wr_en   = req_fire && (req_data.action == ACT_WRITE_NODE) &&
                    (32'(req_data.node_slot) < 32'(NODE_COUNT));
      tbl_wr_addr = req_data.node_slot[NODE_W-1:0];
      tbl_wr_data.split_feature   = req_data.split_feature;
      tbl_wr_data.split_threshold = req_data.split_threshold;
      tbl_wr_data.left_child      = req_data.left_child;
      tbl_wr_data.right_child     = req_data.right_child;
      tbl_wr_data.is_leaf         = req_data.is_leaf;
      if (32'(req_data.leaf_class) > 32'(CLASS_COUNT - 1)) begin
         tbl_wr_data.leaf_class = 4'(CLASS_COUNT - 1);
      end else begin
         tbl_wr_data.leaf_class = req_data.leaf_class;
      end
   end

   dti_ram #(
      .WIDTH ($bits(node_type)),
      .DEPTH (NODE_COUNT)
   ) u_node_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_raw)
   );

   assign node_rd = node_type'(tbl_rd_raw);

   // sample buffer, written only while idle
   always_ff @(posedge clock) begin
      if (req_fire && (req_data.action == ACT_WRITE_FEATURE) &&
          (32'(req_data.feature_slot) < 32'(FEATURE_COUNT))) begin
         sample_ff[req_data.feature_slot[FEAT_W-1:0]] <= req_data.feature_value;
      end
   end

   // compare of the current node; feature index wraps on the buffer size
   assign feat_val = sample_ff[node_rd.split_feature[FEAT_W-1:0]];
   assign go_left  = (feat_val <= node_rd.split_threshold);
   assign at_limit = (depth_ff == DEPTH_W'(MAX_DEPTH));

   // walk sequencer
   always_comb begin
      state_in    = state_ff;
      depth_in    = depth_ff;
      tbl_rd_en   = 1'b0;
      tbl_rd_addr = '0;
      rsp_load    = 1'b0;
      rsp_data_in = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            // root read goes out in the same cycle the beat is taken
            if (req_fire && (req_data.action == ACT_CLASSIFY)) begin
               tbl_rd_en   = 1'b1;
               tbl_rd_addr = '0;
               depth_in    = '0;
               state_in    = ST_WALK;
            end
         end
         ST_WALK: begin
            if (node_rd.is_leaf || at_limit) begin
               // hold the node read until the response slot frees up
               if (out_free) begin
                  rsp_load = 1'b1;
                  state_in = ST_IDLE;
                  if (node_rd.is_leaf) begin
                     rsp_data_in.predicted_class = node_rd.leaf_class;
                     rsp_data_in.depth_exceeded  = 1'b0;
                  end else begin
                     rsp_data_in.predicted_class = '0;
                     rsp_data_in.depth_exceeded  = 1'b1;
                  end
               end
            end else begin
               // descend: child index wraps on the table size
               tbl_rd_en = 1'b1;
               if (go_left) begin
                  tbl_rd_addr = node_rd.left_child[NODE_W-1:0];
               end else begin
                  tbl_rd_addr = node_rd.right_child[NODE_W-1:0];
               end
               depth_in = depth_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a classify beat always starts a walk
   a_classify_walks: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_data.action == ACT_CLASSIFY)) |=> (state_ff == ST_WALK))
      else $error("classify beat did not start a walk");

   // the descent counter never runs past the depth limit
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (32'(depth_ff) <= 32'(MAX_DEPTH)))
      else $error("walk depth beyond limit");

   // a response is only loaded into a free slot
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten before taken");

   // an aborted walk reports class zero
   a_abort_class: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.depth_exceeded) |-> (rsp_data_ff.predicted_class == '0))
      else $error("depth exceeded with non-zero class");

endmodule

### hw/rtl/dti_ram.sv
`timescale 1ns / 1ps

module dti_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
